// ===== rtl/ssnis_pkg.sv =====
package ssnis_pkg;

  localparam int unsigned MaxItems    = 8;
  localparam int unsigned MaxSectors  = 16;
  localparam int unsigned CordicSteps = 28;
  localparam int unsigned CordicW     = 34;  // holds |v| << 14 times CORDIC gain plus sign

  localparam logic [3:0] NoneSelected = 4'hF;

  // APB register word indexes
  localparam logic [1:0] RegSectorCount = 2'd0;
  localparam logic [1:0] RegItemCount   = 2'd1;
  localparam logic [1:0] RegItemOrders  = 2'd2;

  localparam logic [31:0] TurnQuarter      = 32'h4000_0000;
  localparam logic [31:0] TurnHalf         = 32'h8000_0000;
  localparam logic [31:0] TurnThreeQuarter = 32'hC000_0000;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:    v = 32'h2000_0000;
      5'd1:    v = 32'h12E4_051E;
      5'd2:    v = 32'h09FB_385B;
      5'd3:    v = 32'h0511_11D4;
      5'd4:    v = 32'h028B_0D43;
      5'd5:    v = 32'h0145_D7E1;
      5'd6:    v = 32'h00A2_F61E;
      5'd7:    v = 32'h0051_7C55;
      5'd8:    v = 32'h0028_BE53;
      5'd9:    v = 32'h0014_5F2F;
      5'd10:   v = 32'h000A_2F98;
      5'd11:   v = 32'h0005_17CC;
      5'd12:   v = 32'h0002_8BE6;
      5'd13:   v = 32'h0001_45F3;
      5'd14:   v = 32'h0000_A2FA;
      5'd15:   v = 32'h0000_517D;
      5'd16:   v = 32'h0000_28BE;
      5'd17:   v = 32'h0000_145F;
      5'd18:   v = 32'h0000_0A30;
      5'd19:   v = 32'h0000_0518;
      5'd20:   v = 32'h0000_028C;
      5'd21:   v = 32'h0000_0146;
      5'd22:   v = 32'h0000_00A3;
      5'd23:   v = 32'h0000_0051;
      5'd24:   v = 32'h0000_0029;
      5'd25:   v = 32'h0000_0014;
      5'd26:   v = 32'h0000_000A;
      5'd27:   v = 32'h0000_0005;
      default: v = 32'h0000_0000;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/stick_sector_nearest_item_select.sv =====
// From accept to result: 28 CORDIC steps, ST_ANGLE, ST_SECTOR, one scan step per
//   placed item plus one to end the scan, then ST_FINISH loads the output.
//   On an axis CORDIC is skipped; zero vector or zero sector count: ST_FINISH only.
// Throughput: one request in flight, next taken the cycle after the result loads.
// Reset (rst_ni, async, low): idle, output empty, sector_count 8, item_count 0,
//   item_orders 0, current selection none.
module stick_sector_nearest_item_select import ssnis_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] stick_x, [31:16] stick_y
  // stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [0] sector_valid, [4:1] sector_index,
                                      // [5] select_valid, [8:6] select_index,
                                      // [9] select_changed, [15:10] zero
  // APB config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_ANGLE,
    ST_SECTOR,
    ST_SCAN,
    ST_FINISH
  } state_e;

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [4:0]  sector_count_q;
  logic [3:0]  item_count_q;
  logic [31:0] item_orders_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sector_count_q <= 5'd8;
      item_count_q   <= 4'd0;
      item_orders_q  <= 32'd0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegSectorCount: sector_count_q <= pwdata[4:0];
        RegItemCount:   item_count_q   <= pwdata[3:0];
        RegItemOrders:  item_orders_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegSectorCount: prdata = {27'd0, sector_count_q};
      RegItemCount:   prdata = {28'd0, item_count_q};
      RegItemOrders:  prdata = item_orders_q;
      default:        prdata = 32'd0;
    endcase
  end

  // Clamped settings in effect
  logic [4:0] n_eff;
  logic [3:0] items_eff;
  assign n_eff     = (sector_count_q > 5'(MaxSectors)) ? 5'(MaxSectors) : sector_count_q;
  assign items_eff = (item_count_q > 4'(MaxItems)) ? 4'(MaxItems) : item_count_q;

  // ---------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------
  state_e state_q;
  logic signed [CordicW-1:0] x_q, y_q;
  logic [31:0] z_q;
  logic [4:0]  iter_q;         // CORDIC step, 0..27
  logic        x_neg_q, y_neg_q, x_zero_q, y_zero_q;
  logic [15:0] r_q;            // angle + quarter turn, wrapped
  logic [3:0]  sector_q;
  logic        sector_valid_q;
  logic [3:0]  scan_q;         // item under test, 0..8
  logic [3:0]  closest_q;
  logic        best_q;         // distance of current winner (0 or 1)
  logic [3:0]  cur_sel_q;      // selection kept between requests
  logic        out_valid_q;
  logic [9:0]  out_data_q;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_data_q};

  // Input decode
  logic signed [15:0] sx, sy;
  logic [16:0] ax, ay;
  assign sx = s_axis_tdata[15:0];
  assign sy = s_axis_tdata[31:16];
  assign ax = sx[15] ? 17'(-{sx[15], sx}) : {1'b0, sx};
  assign ay = sy[15] ? 17'(-{sy[15], sy}) : {1'b0, sy};

  // Shared CORDIC step: floor shifts and rotate toward y = 0
  logic signed [CordicW-1:0] dx, dy;
  logic y_pos;
  assign dx    = y_q >>> iter_q;
  assign dy    = x_q >>> iter_q;
  assign y_pos = !y_q[CordicW-1] && (y_q != '0);

  // Full-circle angle from quadrant result
  logic [31:0] a32, a_rnd;
  always_comb begin
    priority if (y_zero_q) begin
      a32 = x_neg_q ? TurnHalf : 32'd0;
    end else if (x_zero_q) begin
      a32 = y_neg_q ? TurnThreeQuarter : TurnQuarter;
    end else begin
      unique case ({x_neg_q, y_neg_q})
        2'b00: a32 = z_q;
        2'b10: a32 = TurnHalf - z_q;
        2'b11: a32 = TurnHalf + z_q;
        default: a32 = 32'd0 - z_q;
      endcase
    end
    a_rnd = a32 + 32'h0000_8000;  // round to 16 bits
  end

  // Quantize: (r*2n + 2^16) >> 17, wrap n to 0
  logic [20:0] prod;
  logic [21:0] qsum;
  logic [4:0]  sec_raw, sec_fix;
  assign prod    = 21'(r_q) * 21'(n_eff);
  assign qsum    = {prod, 1'b0} + 22'h01_0000;
  assign sec_raw = qsum[21:17];
  assign sec_fix = (sec_raw >= n_eff) ? sec_raw - n_eff : sec_raw;

  // Item distance check
  logic [3:0] ord, d1;
  logic [4:0] d2, item_dist;
  logic       hit;
  assign ord       = item_orders_q[{scan_q[2:0], 2'b00} +: 4];
  assign d1        = (sector_q > ord) ? sector_q - ord : ord - sector_q;
  assign d2        = n_eff - {1'b0, d1};
  assign item_dist = ({1'b0, d1} < d2) ? {1'b0, d1} : d2;
  assign hit       = ({1'b0, ord} < n_eff) && (item_dist < 5'd2) &&
                     ((closest_q == NoneSelected) || (item_dist[0] < best_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      out_valid_q    <= 1'b0;
      out_data_q     <= '0;
      cur_sel_q      <= NoneSelected;
      x_q            <= '0;
      y_q            <= '0;
      z_q            <= '0;
      iter_q         <= '0;
      x_neg_q        <= 1'b0;
      y_neg_q        <= 1'b0;
      x_zero_q       <= 1'b0;
      y_zero_q       <= 1'b0;
      r_q            <= '0;
      sector_q       <= '0;
      scan_q         <= '0;
      closest_q      <= NoneSelected;
      best_q         <= 1'b0;
      sector_valid_q <= 1'b0;
    end else begin
      // result taken; ST_FINISH reloads it on its own
      if (out_valid_q && m_axis_tready && state_q != ST_FINISH) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            x_q       <= CordicW'({ax, 14'd0});
            y_q       <= CordicW'({ay, 14'd0});
            z_q       <= '0;
            iter_q    <= '0;
            scan_q    <= '0;
            x_neg_q   <= sx[15];
            y_neg_q   <= sy[15];
            x_zero_q  <= (sx == '0);
            y_zero_q  <= (sy == '0);
            closest_q <= NoneSelected;
            best_q    <= 1'b0;
            sector_q  <= '0;
            sector_valid_q <= 1'b0;
            priority if (n_eff == '0 || (sx == '0 && sy == '0)) begin
              state_q <= ST_FINISH;
            end else if (sx == '0 || sy == '0) begin
              state_q <= ST_ANGLE;  // on an axis: exact angle
            end else begin
              state_q <= ST_CORDIC;
            end
          end
        end
        ST_CORDIC: begin
          if (y_pos) begin
            x_q <= x_q + dx;
            y_q <= y_q - dy;
            z_q <= z_q + atan_turn(iter_q);
          end else begin
            x_q <= x_q - dx;
            y_q <= y_q + dy;
            z_q <= z_q - atan_turn(iter_q);
          end
          iter_q <= iter_q + 5'd1;
          if (iter_q == 5'(CordicSteps - 1)) begin
            state_q <= ST_ANGLE;
          end
        end
        ST_ANGLE: begin
          r_q     <= a_rnd[31:16] + 16'h4000;
          state_q <= ST_SECTOR;
        end
        ST_SECTOR: begin
          sector_q       <= sec_fix[3:0];
          sector_valid_q <= 1'b1;
          state_q        <= ST_SCAN;
        end
        ST_SCAN: begin
          if (scan_q == items_eff) begin
            state_q <= ST_FINISH;
          end else begin
            if (hit) begin
              closest_q <= scan_q;
              best_q    <= item_dist[0];
            end
            scan_q <= scan_q + 4'd1;
          end
        end
        ST_FINISH: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {(closest_q != cur_sel_q),
                            (closest_q != NoneSelected) ? closest_q[2:0] : 3'd0,
                            (closest_q != NoneSelected),
                            sector_valid_q ? sector_q : 4'd0,
                            sector_valid_q};
            cur_sel_q   <= closest_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cordic_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CORDIC) |=> (state_q == ST_CORDIC || state_q == ST_ANGLE))
    else $error("CORDIC left to wrong state");

  a_select_needs_sector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_data_q[5] || out_data_q[0]))
    else $error("selection without sector");

  a_cur_sel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_sel_q == NoneSelected) || !cur_sel_q[3])
    else $error("kept selection out of range");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !s_axis_tready)
    else $error("ready while scanning");
`endif

endmodule

// ===== bench/stick_sector_nearest_item_select_tb.sv =====
module stick_sector_nearest_item_select_tb;
  import ssnis_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit   = 400_000;
  localparam int unsigned RandomPhases = 15;
  localparam int unsigned PhaseSamples = 60;
  localparam int unsigned DrainCycles  = 60;   // idle time after the last result is checked

  // atan(2^-i), units of 2^-32 turn
  localparam longint AtanTurn [28] = '{
    64'h2000_0000, 64'h12E4_051E, 64'h09FB_385B, 64'h0511_11D4, 64'h028B_0D43,
    64'h0145_D7E1, 64'h00A2_F61E, 64'h0051_7C55, 64'h0028_BE53, 64'h0014_5F2F,
    64'h000A_2F98, 64'h0005_17CC, 64'h0002_8BE6, 64'h0001_45F3, 64'h0000_A2FA,
    64'h0000_517D, 64'h0000_28BE, 64'h0000_145F, 64'h0000_0A30, 64'h0000_0518,
    64'h0000_028C, 64'h0000_0146, 64'h0000_00A3, 64'h0000_0051, 64'h0000_0029,
    64'h0000_0014, 64'h0000_000A, 64'h0000_0005
  };

  // Stick values worth hitting on purpose: full scale both ways, one LSB, zero
  localparam logic [15:0] EdgeVals [5] = '{16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF, 16'h0000};

  // One result; packed so that it lines up with m_axis_tdata[9:0]
  typedef struct packed {
    logic       sel_changed;
    logic [2:0] sel_index;
    logic       sel_valid;
    logic [3:0] sec_index;
    logic       sec_valid;
  } pointer_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [15:0] stick_x, [31:16] stick_y
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [0] sector_valid, [4:1] sector_index, [5] select_valid,
                               // [8:6] select_index, [9] select_changed, [15:10] zero
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  stick_sector_nearest_item_select dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Shadow of the block: register copies and the held selection
  logic [4:0]  cfg_sector_count = 5'd8;
  logic [3:0]  cfg_item_count   = 4'd0;
  logic [31:0] cfg_item_orders  = 32'd0;
  logic [3:0]  held_selection   = NoneSelected;

  pointer_result_t pointer_results_due[$];
  pointer_result_t want;

  // Per-side idle bound, changed per phase (0 gives back-to-back traffic)
  int unsigned in_max_gap    = 0;
  int unsigned out_max_stall = 0;

  logic [15:0] last_x = 16'd0;
  logic [15:0] last_y = 16'd0;

  int unsigned errors          = 0;
  int unsigned cycle_count     = 0;
  int unsigned samples_sent    = 0;
  int unsigned writes_done     = 0;
  int unsigned results_checked = 0;
  int unsigned selections_seen = 0;
  int unsigned changes_seen    = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run-away guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results still due", cycle_count,
               pointer_results_due.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Angle of the stick in 2^-16 turn, counterclockwise from +x.
  // Off-axis vectors go through a 28-step CORDIC on |x|,|y| in the first quadrant.
  function automatic logic [15:0] stick_turn16(logic signed [15:0] sx, logic signed [15:0] sy);
    longint     ax, ay, cx, cy, cz, dx, dy;
    logic [31:0] a32;
    logic [31:0] zq;
    logic [32:0] rounded;
    if (sy == 0) begin
      a32 = (sx > 0) ? 32'd0 : TurnHalf;
    end else if (sx == 0) begin
      a32 = (sy > 0) ? TurnQuarter : TurnThreeQuarter;
    end else begin
      ax = (sx < 0) ? -longint'(sx) : longint'(sx);
      ay = (sy < 0) ? -longint'(sy) : longint'(sy);
      cx = ax <<< 14;
      cy = ay <<< 14;
      cz = 0;
      for (int i = 0; i < 28; i++) begin
        dx = cy >>> i;   // arithmetic shift floors negatives
        dy = cx >>> i;
        if (cy > 0) begin
          cx = cx + dx;
          cy = cy - dy;
          cz = cz + AtanTurn[i];
        end else begin
          cx = cx - dx;
          cy = cy + dy;
          cz = cz - AtanTurn[i];
        end
      end
      zq = cz[31:0];
      if (sx > 0 && sy > 0)      a32 = zq;
      else if (sx < 0 && sy > 0) a32 = TurnHalf - zq;
      else if (sx < 0)           a32 = TurnHalf + zq;
      else                       a32 = 32'd0 - zq;
    end
    // round half up to 16 bits, then wrap
    rounded = {1'b0, a32} + 33'h0_0000_8000;
    return rounded[31:16];
  endfunction

  // Expected result for one accepted sample; advances the held selection
  function automatic pointer_result_t predict_pointer(logic [15:0] x_raw, logic [15:0] y_raw);
    pointer_result_t res;
    logic [15:0]     rot;
    logic [3:0]      closest;
    int unsigned     n, items, sector, best, ord, d1, d2, d;
    res     = '0;
    closest = NoneSelected;
    best    = 0;
    n       = (cfg_sector_count > MaxSectors) ? MaxSectors : cfg_sector_count;
    items   = (cfg_item_count > MaxItems) ? MaxItems : cfg_item_count;
    if (n != 0 && (x_raw != 16'd0 || y_raw != 16'd0)) begin
      // quarter turn so that down sits in sector 0, then half a sector for centering
      rot    = stick_turn16(x_raw, y_raw) + 16'h4000;
      sector = (int'(rot) * 2 * n + 32'h1_0000) >> 17;
      if (sector >= n) sector = sector - n;
      res.sec_valid = 1'b1;
      res.sec_index = sector[3:0];
      for (int i = 0; i < items; i++) begin
        ord = cfg_item_orders[4*i +: 4];
        if (ord < n) begin   // items placed past the last sector never win
          d1 = (sector > ord) ? sector - ord : ord - sector;
          d2 = n - d1;
          d  = (d1 < d2) ? d1 : d2;
          // strict compare keeps the lower index on ties
          if (d < 2 && (closest == NoneSelected || d < best)) begin
            closest = 4'(i);
            best    = d;
          end
        end
      end
    end
    res.sel_changed = (closest != held_selection);
    res.sel_valid   = (closest != NoneSelected);
    res.sel_index   = res.sel_valid ? closest[2:0] : 3'd0;
    held_selection  = closest;
    return res;
  endfunction

  task automatic report_mismatch(string field, int got, int exp_val);
    errors++;
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, field, got, exp_val);
  endtask

  // Result checker: every handshake on the output pops the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pointer_results_due.size() == 0) begin
        report_mismatch("result with nothing due, tdata", m_axis_tdata, 0);
      end else begin
        want = pointer_results_due.pop_front();
        results_checked++;
        if (want.sel_valid)   selections_seen++;
        if (want.sel_changed) changes_seen++;
        if (m_axis_tdata[0] !== want.sec_valid)
          report_mismatch("sector_valid", m_axis_tdata[0], want.sec_valid);
        if (m_axis_tdata[4:1] !== want.sec_index)
          report_mismatch("sector_index", m_axis_tdata[4:1], want.sec_index);
        if (m_axis_tdata[5] !== want.sel_valid)
          report_mismatch("select_valid", m_axis_tdata[5], want.sel_valid);
        if (m_axis_tdata[8:6] !== want.sel_index)
          report_mismatch("select_index", m_axis_tdata[8:6], want.sel_index);
        if (m_axis_tdata[9] !== want.sel_changed)
          report_mismatch("select_changed", m_axis_tdata[9], want.sel_changed);
        if (m_axis_tdata[15:10] !== 6'd0)
          report_mismatch("tdata pad", m_axis_tdata[15:10], 0);
      end
    end
  end

  // Output side: random stall before each result
  initial begin
    int unsigned stall;
    m_axis_tready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      stall = $urandom_range(0, out_max_stall);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // One request; valid stays up across back-to-back requests
  task automatic send_stick(logic [15:0] x, logic [15:0] y);
    int unsigned gap;
    gap = $urandom_range(0, in_max_gap);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    pointer_results_due.push_back(predict_pointer(x, y));
    samples_sent++;
    last_x = x;
    last_y = y;
  endtask

  // Register write; waits until the block has drained every request first
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    s_axis_tvalid <= 1'b0;
    while (pointer_results_due.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegSectorCount: cfg_sector_count = val[4:0];
      RegItemCount:   cfg_item_count   = val[3:0];
      RegItemOrders:  cfg_item_orders  = val;
      default: ;
    endcase
    writes_done++;
  endtask

  task automatic set_menu(logic [4:0] sectors, logic [3:0] items, logic [31:0] orders);
    write_reg(RegSectorCount, {27'd0, sectors});
    write_reg(RegItemCount, {28'd0, items});
    write_reg(RegItemOrders, orders);
  endtask

  // Out of reset: 8 sectors, no items, so nothing can ever be selected
  task automatic test_reset_state();
    send_stick(16'h0000, 16'h0000);
    send_stick(16'h7FFF, 16'h0000);
    send_stick(16'h0000, 16'h8000);
    send_stick(16'h1234, 16'hEDCC);
  endtask

  // Exact axes, full-scale corners and one-LSB vectors with a full menu
  task automatic test_axes_and_extremes();
    set_menu(5'd8, 4'd8, 32'h7654_3210);
    send_stick(16'h7FFF, 16'h0000);
    send_stick(16'h8000, 16'h0000);
    send_stick(16'h0000, 16'h7FFF);
    send_stick(16'h0000, 16'h8000);
    send_stick(16'h8000, 16'h8000);
    send_stick(16'h7FFF, 16'h7FFF);
    send_stick(16'h8000, 16'h7FFF);
    send_stick(16'h7FFF, 16'h8000);
    send_stick(16'h0001, 16'h0001);
    send_stick(16'hFFFF, 16'hFFFF);
    send_stick(16'h0000, 16'h0000);   // zero vector clears the selection
  endtask

  // Zero sectors, one sector, and counts above the sector limit
  task automatic test_sector_count_limits();
    set_menu(5'd0, 4'd8, 32'h7654_3210);
    send_stick(16'h4000, 16'h4000);
    set_menu(5'd31, 4'd15, 32'hFFFF_FFFF);
    send_stick(16'hC000, 16'h2000);
    send_stick(16'h2000, 16'hC000);
    set_menu(5'd1, 4'd2, 32'h0000_0010);
    send_stick(16'h0100, 16'hFF00);
    send_stick(16'h8000, 16'h0001);
  endtask

  // Items past the last sector, tied items, and an item count above the limit
  task automatic test_item_placement();
    set_menu(5'd4, 4'd15, 32'hFFFF_1139);
    send_stick(16'h7FFF, 16'h0000);
    send_stick(16'h0000, 16'h7FFF);
    send_stick(16'h8000, 16'h0000);
    set_menu(5'd16, 4'd8, 32'h1F0E_2F01);
    send_stick(16'h0000, 16'h7FFF);
  endtask

  // Mostly well-formed menus with stick motion that lingers and moves on
  task automatic test_random_sweep();
    logic [4:0]  sectors;
    logic [3:0]  items;
    logic [31:0] orders;
    logic [15:0] x, y;
    int unsigned n;
    for (int ph = 0; ph < RandomPhases; ph++) begin
      case (ph % 4)
        0: begin in_max_gap = 0;  out_max_stall = 0;  end
        1: begin in_max_gap = 18; out_max_stall = 18; end
        2: begin in_max_gap = 0;  out_max_stall = 18; end
        default: begin in_max_gap = 18; out_max_stall = 0; end
      endcase
      if (ph == 0)      sectors = 5'd16;
      else if (ph == 1) sectors = 5'd1;
      else if ($urandom_range(0, 9) < 7) sectors = 5'($urandom_range(2, 16));
      else sectors = 5'($urandom_range(0, 31));
      items = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                         : 4'($urandom_range(1, 8));
      n = (sectors > MaxSectors) ? MaxSectors : sectors;
      if (n == 0 || $urandom_range(0, 4) == 0) begin
        orders = $urandom;
      end else begin
        for (int i = 0; i < 8; i++) orders[4*i +: 4] = 4'($urandom_range(0, n - 1));
      end
      set_menu(sectors, items, orders);
      for (int k = 0; k < PhaseSamples; k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin x = 16'($urandom); y = 16'($urandom); end
          3: begin   // tiny deflections, coarse angles
            x = 16'($urandom_range(0, 8) - 4);
            y = 16'($urandom_range(0, 8) - 4);
          end
          4: begin
            if ($urandom_range(0, 1) == 0) begin x = 16'($urandom); y = 16'd0; end
            else begin x = 16'd0; y = 16'($urandom); end
          end
          5: begin
            x = EdgeVals[$urandom_range(0, 4)];
            y = EdgeVals[$urandom_range(0, 4)];
          end
          6, 7: begin   // drift from the last sample: walks across sector borders
            x = last_x + 16'($urandom_range(0, 4096) - 2048);
            y = last_y + 16'($urandom_range(0, 4096) - 2048);
          end
          8: begin x = last_x; y = last_y; end
          default: begin
            if ($urandom_range(0, 3) == 0) begin x = 16'd0; y = 16'd0; end
            else begin x = 16'($urandom); y = 16'($urandom); end
          end
        endcase
        send_stick(x, y);
      end
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 32'd0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= 4'd0;
    pwdata        <= 32'd0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    in_max_gap    = 18;
    out_max_stall = 18;
    test_axes_and_extremes();
    test_sector_count_limits();
    test_item_placement();
    test_random_sweep();

    s_axis_tvalid <= 1'b0;
    while (pointer_results_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (pointer_results_due.size() != 0)
      report_mismatch("results never delivered", 0, pointer_results_due.size());

    $display("Sent %0d stick samples across %0d register writes; checked %0d results.",
             samples_sent, writes_done, results_checked);
    $display("Results with a selection: %0d, with a selection change: %0d, mismatches: %0d.",
             selections_seen, changes_seen, errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
